>>> rtl/bst_pkg.sv
// Shared types, codes and defaults for the bencode stream tokenizer.
`default_nettype none

package bst_pkg;

	// Parameter defaults and fixed sizes
	localparam int MAX_DEPTH_DEF = 32;
	localparam int LEN_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH   = 2;
	localparam int ACC_W         = 63;

	// Characters of the bencode grammar
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Byte classes seen by the parser
	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_I,
		CLS_L,
		CLS_D,
		CLS_E,
		CLS_COLON,
		CLS_MINUS,
		CLS_OTHER
	} cls_t;

	// Event kinds on the result side
	typedef enum logic [2:0] {
		KIND_INT,
		KIND_STR_HDR,
		KIND_STR_BYTE,
		KIND_LIST_OPEN,
		KIND_DICT_OPEN,
		KIND_CLOSE,
		KIND_ERROR,
		KIND_COMPLETE
	} kind_t;

	// Error codes
	typedef enum logic [3:0] {
		ERR_UNEXPECTED,
		ERR_INT_DIGIT,
		ERR_INT_NO_E,
		ERR_INT_EMPTY,
		ERR_LEN_CHAR,
		ERR_NO_COLON,
		ERR_STR_SHORT,
		ERR_LIST_NO_E,
		ERR_DICT_NO_E,
		ERR_EOF,
		ERR_OVERFLOW
	} err_t;

	// Parser modes
	typedef enum logic [2:0] {
		MODE_EXPECT,
		MODE_INT_SIGN,
		MODE_INT_DIGITS,
		MODE_STR_LEN,
		MODE_STR_BODY,
		MODE_DONE,
		MODE_ERROR
	} mode_t;

	// Decoded parser operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_FAIL,
		OP_INT_START,
		OP_INT_NEG,
		OP_INT_DIGIT,
		OP_INT_DONE,
		OP_STR_START,
		OP_LEN_DIGIT,
		OP_STR_HDR,
		OP_STR_BYTE,
		OP_OPEN,
		OP_CLOSE,
		OP_EOF_DONE,
		OP_EOF_FAIL,
		OP_EOF_QUIET
	} op_t;

	// Classified request from the front end
	typedef struct packed {
		logic        eof;
		cls_t        cls;
		logic [3:0]  digit;
		logic [7:0]  data;
	} tok_t;

	// One result event
	typedef struct packed {
		kind_t              kind;
		logic signed [63:0] int_value;
		logic [31:0]        str_length;
		logic [7:0]         data_byte;
		logic               last_byte;
		logic               is_key;
		logic [5:0]         nest_depth;
		logic               top_done;
		err_t               error_code;
	} evt_t;

endpackage

`default_nettype wire

>>> rtl/bst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bst_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/bst_fifo.sv
// Small register FIFO used between the front end, the parser and the result port.
`default_nettype none

module bst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/bst_front.sv
// Front end: accepts input requests and classifies each byte for the parser.
`default_nettype none

module bst_front import bst_pkg::*; (
	input  wire logic       push,
	output logic            full,
	input  wire logic       action,
	input  wire logic [7:0] in_byte,
	input  wire logic       q_full,
	output logic            q_push,
	output tok_t            tok
);

	// Accept whenever the classified queue has room
	assign full   = q_full;
	assign q_push = push && !q_full;

	// Classify the byte
	always_comb begin
		tok       = '0;
		tok.eof   = action;
		tok.data  = in_byte;
		tok.digit = in_byte[3:0];
		if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
			tok.cls = CLS_DIGIT;
		end else begin
			case (in_byte)
				CH_I:     tok.cls = CLS_I;
				CH_L:     tok.cls = CLS_L;
				CH_D:     tok.cls = CLS_D;
				CH_E:     tok.cls = CLS_E;
				CH_COLON: tok.cls = CLS_COLON;
				CH_MINUS: tok.cls = CLS_MINUS;
				default:  tok.cls = CLS_OTHER;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/bst_back.sv
// Back end: bencode parser state machine with the container stack.
`default_nettype none

module bst_back import bst_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int LEN_BITS  = LEN_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tok_t tok,
	input  wire logic tok_valid,
	output logic      tok_pop,
	input  wire logic evt_full,
	output logic      evt_push,
	output evt_t      evt
);

	localparam int SPW = $clog2(MAX_DEPTH + 1);
	localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	mode_t               mode_q, mode_d;
	logic [SPW-1:0]      sp_q, sp_d;
	logic [ACC_W-1:0]    acc_q, acc_d;
	logic                neg_q, neg_d;
	logic                seen_q, seen_d;
	logic [LEN_BITS-1:0] rem_q, rem_d;
	logic                key_q, key_d;
	logic                top_dict_q, top_dict_d;
	logic                byp_q;
	logic                byp_dat_q;
	logic                ram_rd;
	logic                ram_we;
	logic                below_dict;
	logic                go;
	op_t                 op;
	err_t                err;
	logic [ACC_W+3:0]    sum;
	logic                int_ovf;
	logic                len_ovf;
	logic                sp_zero;
	logic                in_dict;
	logic                top_list;
	logic                at_max;
	logic                rem_last;
	logic                acc_zero;
	logic                open_dict;
	logic                finish;
	logic [63:0]         mag;

	// Take a request when one waits and the result queue has room
	assign go      = tok_valid && !evt_full;
	assign tok_pop = go;

	// Stack status
	assign sp_zero    = (sp_q == '0);
	assign in_dict    = !sp_zero && top_dict_q;
	assign top_list   = !sp_zero && !top_dict_q;
	assign at_max     = (sp_q >= SPW'(MAX_DEPTH));
	assign below_dict = byp_q ? byp_dat_q : ram_rd;
	assign open_dict  = (tok.cls == CLS_D);

	// Accumulate a decimal digit and check both range limits
	assign sum      = (ACC_W+4)'({acc_q, 3'b000}) + (ACC_W+4)'({acc_q, 1'b0})
		+ (ACC_W+4)'(tok.digit);
	assign int_ovf  = |sum[ACC_W+3:ACC_W];
	assign len_ovf  = |sum[ACC_W+3:LEN_BITS];
	assign rem_last = (rem_q == LEN_BITS'(1));
	assign acc_zero = (acc_q == '0);
	assign mag      = {1'b0, acc_q};

	// Decode the request against the current mode
	always_comb begin
		op  = OP_NONE;
		err = ERR_UNEXPECTED;
		if (tok.eof) begin
			case (mode_q)
				MODE_DONE:  op = OP_EOF_DONE;
				MODE_ERROR: op = OP_EOF_QUIET;
				MODE_INT_SIGN, MODE_INT_DIGITS: begin
					op  = OP_EOF_FAIL;
					err = ERR_INT_NO_E;
				end
				MODE_STR_LEN: begin
					op  = OP_EOF_FAIL;
					err = ERR_NO_COLON;
				end
				MODE_STR_BODY: begin
					op  = OP_EOF_FAIL;
					err = ERR_STR_SHORT;
				end
				default: begin
					op = OP_EOF_FAIL;
					if (sp_zero) begin
						err = ERR_EOF;
					end else if (!top_dict_q) begin
						err = ERR_LIST_NO_E;
					end else begin
						err = key_q ? ERR_DICT_NO_E : ERR_EOF;
					end
				end
			endcase
		end else begin
			case (mode_q)
				MODE_DONE, MODE_ERROR: op = OP_NONE;
				MODE_INT_SIGN, MODE_INT_DIGITS: begin
					if (tok.cls == CLS_E) begin
						if (seen_q) begin
							op = OP_INT_DONE;
						end else begin
							op  = OP_FAIL;
							err = ERR_INT_EMPTY;
						end
					end else if (mode_q == MODE_INT_SIGN && tok.cls == CLS_MINUS) begin
						op = OP_INT_NEG;
					end else if (tok.cls != CLS_DIGIT) begin
						op  = OP_FAIL;
						err = ERR_INT_DIGIT;
					end else if (int_ovf) begin
						op  = OP_FAIL;
						err = ERR_OVERFLOW;
					end else begin
						op = OP_INT_DIGIT;
					end
				end
				MODE_STR_LEN: begin
					if (tok.cls == CLS_COLON) begin
						op = OP_STR_HDR;
					end else if (tok.cls != CLS_DIGIT) begin
						op  = OP_FAIL;
						err = ERR_LEN_CHAR;
					end else if (len_ovf) begin
						op  = OP_FAIL;
						err = ERR_OVERFLOW;
					end else begin
						op = OP_LEN_DIGIT;
					end
				end
				MODE_STR_BODY: op = OP_STR_BYTE;
				default: begin
					if (in_dict && key_q) begin
						// Dict key position: only a string or a close
						if (tok.cls == CLS_E) begin
							op = OP_CLOSE;
						end else if (tok.cls == CLS_DIGIT) begin
							op = OP_STR_START;
						end else begin
							op  = OP_FAIL;
							err = (tok.cls == CLS_COLON) ? ERR_NO_COLON : ERR_LEN_CHAR;
						end
					end else begin
						case (tok.cls)
							CLS_E: begin
								if (top_list) begin
									op = OP_CLOSE;
								end else begin
									op  = OP_FAIL;
									err = ERR_UNEXPECTED;
								end
							end
							CLS_I: op = OP_INT_START;
							CLS_L, CLS_D: begin
								if (at_max) begin
									op  = OP_FAIL;
									err = ERR_OVERFLOW;
								end else begin
									op = OP_OPEN;
								end
							end
							CLS_DIGIT: op = OP_STR_START;
							default: begin
								op  = OP_FAIL;
								err = ERR_UNEXPECTED;
							end
						endcase
					end
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		mode_d     = mode_q;
		sp_d       = sp_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		seen_d     = seen_q;
		rem_d      = rem_q;
		key_d      = key_q;
		top_dict_d = top_dict_q;
		finish     = 1'b0;
		if (go) begin
			case (op)
				OP_FAIL: mode_d = MODE_ERROR;
				OP_INT_START: begin
					acc_d  = '0;
					neg_d  = 1'b0;
					seen_d = 1'b0;
					mode_d = MODE_INT_SIGN;
				end
				OP_INT_NEG: begin
					neg_d  = 1'b1;
					mode_d = MODE_INT_DIGITS;
				end
				OP_INT_DIGIT: begin
					acc_d  = sum[ACC_W-1:0];
					seen_d = 1'b1;
					mode_d = MODE_INT_DIGITS;
				end
				OP_INT_DONE: finish = 1'b1;
				OP_STR_START: begin
					acc_d  = ACC_W'(tok.digit);
					mode_d = MODE_STR_LEN;
				end
				OP_LEN_DIGIT: acc_d = sum[ACC_W-1:0];
				OP_STR_HDR: begin
					if (acc_zero) begin
						finish = 1'b1;
					end else begin
						rem_d  = acc_q[LEN_BITS-1:0];
						mode_d = MODE_STR_BODY;
					end
				end
				OP_STR_BYTE: begin
					rem_d  = rem_q - 1'b1;
					finish = rem_last;
				end
				OP_OPEN: begin
					sp_d       = sp_q + 1'b1;
					top_dict_d = open_dict;
					key_d      = open_dict;
					mode_d     = MODE_EXPECT;
				end
				OP_CLOSE: begin
					sp_d       = sp_q - 1'b1;
					top_dict_d = below_dict;
					if (sp_q == SPW'(1)) begin
						key_d  = 1'b0;
						mode_d = MODE_DONE;
					end else begin
						// A closed container is a finished value of its parent
						key_d  = below_dict;
						mode_d = MODE_EXPECT;
					end
				end
				OP_EOF_DONE, OP_EOF_FAIL, OP_EOF_QUIET: begin
					mode_d = MODE_EXPECT;
					sp_d   = '0;
					acc_d  = '0;
					neg_d  = 1'b0;
					seen_d = 1'b0;
					rem_d  = '0;
					key_d  = 1'b0;
				end
				default: mode_d = mode_q;
			endcase
			// Finish a scalar value
			if (finish) begin
				if (sp_zero) begin
					mode_d = MODE_DONE;
				end else begin
					mode_d = MODE_EXPECT;
					if (top_dict_q) begin
						key_d = !key_q;
					end
				end
			end
		end
	end

	// Result event
	always_comb begin
		evt            = '0;
		evt.nest_depth = 6'(sp_q);
		evt_push       = 1'b0;
		case (op)
			OP_FAIL, OP_EOF_FAIL: begin
				evt.kind       = KIND_ERROR;
				evt.error_code = err;
				evt_push       = go;
			end
			OP_INT_DONE: begin
				evt.kind      = KIND_INT;
				evt.int_value = neg_q ? (64'd0 - mag) : mag;
				evt.top_done  = sp_zero;
				evt_push      = go;
			end
			OP_STR_HDR: begin
				evt.kind       = KIND_STR_HDR;
				evt.str_length = acc_q[31:0];
				evt.is_key     = key_q;
				evt.top_done   = sp_zero && acc_zero;
				evt_push       = go;
			end
			OP_STR_BYTE: begin
				evt.kind      = KIND_STR_BYTE;
				evt.data_byte = tok.data;
				evt.last_byte = rem_last;
				evt.is_key    = key_q;
				evt.top_done  = rem_last && sp_zero;
				evt_push      = go;
			end
			OP_OPEN: begin
				evt.kind       = open_dict ? KIND_DICT_OPEN : KIND_LIST_OPEN;
				evt.nest_depth = 6'(sp_q + 1'b1);
				evt_push       = go;
			end
			OP_CLOSE: begin
				evt.kind       = KIND_CLOSE;
				evt.nest_depth = 6'(sp_q - 1'b1);
				evt.top_done   = (sp_q == SPW'(1));
				evt_push       = go;
			end
			OP_EOF_DONE: begin
				evt.kind       = KIND_COMPLETE;
				evt.nest_depth = '0;
				evt_push       = go;
			end
			default: evt_push = 1'b0;
		endcase
	end

	// Spill the old top to the stack on a push; prefetch the entry under the new top
	assign ram_we = go && (op == OP_OPEN) && !sp_zero;

	bst_ram #(
		.WIDTH (1),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(sp_q - 1'b1)),
		.wdata (top_dict_q),
		.raddr (AW'(sp_d - SPW'(2))),
		.rdata (ram_rd)
	);

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_EXPECT;
			sp_q       <= '0;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
			rem_q      <= '0;
			key_q      <= 1'b0;
			top_dict_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			mode_q     <= mode_d;
			sp_q       <= sp_d;
			acc_q      <= acc_d;
			neg_q      <= neg_d;
			seen_q     <= seen_d;
			rem_q      <= rem_d;
			key_q      <= key_d;
			top_dict_q <= top_dict_d;
			// Cover the read that raced the spill write
			byp_q      <= go && (op == OP_OPEN);
		end
	end

	// Keep the spilled value for the bypass
	always_ff @(posedge clk) begin
		if (go && op == OP_OPEN) begin
			byp_dat_q <= top_dict_q;
		end
	end

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(MAX_DEPTH))
		else $error("stack pointer beyond the stack");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_STR_BODY |-> rem_q != '0)
		else $error("string body with nothing left");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DONE |-> sp_q == '0)
		else $error("value complete with open containers");

	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		go && tok.eof |=> mode_q == MODE_EXPECT && sp_q == '0)
		else $error("end marker did not return to start");

	a_byp_depth: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> sp_q != '0)
		else $error("stack bypass with an empty stack");

endmodule

`default_nettype wire

>>> rtl/bencode_stream_tokenizer.sv
// Bencode stream tokenizer: one byte per request, one event at most per byte.
// Path: an accepted byte waits in the request queue; the parser writes its event into
// the result queue, where it is held until taken while empty is low.
// Throughput: one byte per cycle while the result queue has room, set by the single
// parser step with one stack push or pop and the prefetched entry under the stack top.
// Reset: arst_n clears the queues and the parser; stack entries are not cleared,
// only entries below the stack pointer are ever read.
`default_nettype none

module bencode_stream_tokenizer import bst_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF,
	parameter int LEN_BITS  = LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        action,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic signed [63:0] int_value,
	output logic [31:0]      str_length,
	output logic [7:0]       data_byte,
	output logic             last_byte,
	output logic             is_key,
	output logic [5:0]       nest_depth,
	output logic             top_done,
	output logic [3:0]       error_code
);

	tok_t tok_in;
	tok_t tok_head;
	logic tok_q_push;
	logic tok_q_full;
	logic tok_q_empty;
	logic tok_pop;
	evt_t evt_in;
	evt_t evt_head;
	logic evt_push;
	logic evt_full;

	// Classify incoming bytes
	bst_front u_front (
		.push    (push),
		.full    (full),
		.action  (action),
		.in_byte (in_byte),
		.q_full  (tok_q_full),
		.q_push  (tok_q_push),
		.tok     (tok_in)
	);

	// Decouple the front end from the parser
	bst_fifo #(
		.WIDTH ($bits(tok_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_q_push),
		.wdata  (tok_in),
		.pop    (tok_pop),
		.rdata  (tok_head),
		.full   (tok_q_full),
		.empty  (tok_q_empty)
	);

	// Parse
	bst_back #(
		.MAX_DEPTH (MAX_DEPTH),
		.LEN_BITS  (LEN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok_head),
		.tok_valid (!tok_q_empty),
		.tok_pop   (tok_pop),
		.evt_full  (evt_full),
		.evt_push  (evt_push),
		.evt       (evt_in)
	);

	// Hold results until taken
	bst_fifo #(
		.WIDTH ($bits(evt_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_evt_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (evt_push),
		.wdata  (evt_in),
		.pop    (pop),
		.rdata  (evt_head),
		.full   (evt_full),
		.empty  (empty)
	);

	// Drive the result fields
	assign kind       = evt_head.kind;
	assign int_value  = evt_head.int_value;
	assign str_length = evt_head.str_length;
	assign data_byte  = evt_head.data_byte;
	assign last_byte  = evt_head.last_byte;
	assign is_key     = evt_head.is_key;
	assign nest_depth = evt_head.nest_depth;
	assign top_done   = evt_head.top_done;
	assign error_code = evt_head.error_code;

endmodule

`default_nettype wire
